// File: rtl/core/assert_macros.svh
// Assertion macros shared by the skip-block remapper RTL.
// Expect i_clk and i_rst_n in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold a condition at every edge out of reset.
`define SBR_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Require a consequence in the same cycle.
`define SBR_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Require a consequence in the following cycle.
`define SBR_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sbr_pkg.sv
// Package of the skip-block bad-block remapper: payload types, codes, constants.
// Used by every module of the block but sbr_ram; depends on nothing.
`default_nettype none

package sbr_pkg;

    localparam int MAX_BAD_DEF = 64;
    localparam int MAX_COPIES  = 16;
    localparam int DIV_STEPS   = 17;
    localparam int MUL_STEPS   = 4;
    localparam int ALU_W       = 18;

    localparam logic [16:0] DEV_LIMIT = 17'd65536;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_MAP   = 2'd2,
        CMD_COUNT = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_COPY  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic {
        CFG_COPIES      = 1'b0,
        CFG_BLOCK_COUNT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_HI,
        S_BASE,
        S_SCAN,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  copy;
        logic [15:0] block;
        logic [15:0] mark_block;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] phys_block;
        logic [16:0] usable_count;
    } t_out;

    typedef struct packed {
        logic [4:0]  copies;
        logic [16:0] total;
    } t_cfg;

    typedef struct packed {
        logic valid;
        t_out data;
    } t_res;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

endpackage

`default_nettype wire

// File: rtl/core/sbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module sbr_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/sbr_alu.sv
// Shared add/subtract unit with carry out, reused by divide, multiply, setup and finish steps.
// Depends on sbr_pkg for the request type.
`default_nettype none

module sbr_alu (
    input  wire sbr_pkg::t_alu_req          i_req,
    output logic [sbr_pkg::ALU_W-1:0]       o_sum,
    output logic                            o_carry
);

    logic [sbr_pkg::ALU_W-1:0] w_b;

    assign w_b = i_req.sub ? ~i_req.b : i_req.b;
    assign {o_carry, o_sum} = {1'b0, i_req.a} + {1'b0, w_b}
                            + (sbr_pkg::ALU_W + 1)'(i_req.sub);

endmodule

`default_nettype wire

// File: rtl/core/sbr_seq.sv
// Sequencer of the remapper: region divide, base multiply, table walk and sorted insert.
// Depends on sbr_pkg, sbr_alu, sbr_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sbr_seq #(
    parameter int MAX_BAD = sbr_pkg::MAX_BAD_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire sbr_pkg::t_in  i_item,
    input  wire sbr_pkg::t_cfg i_cfg,
    input  wire logic          i_res_take,
    output logic               o_busy,
    output sbr_pkg::t_res      o_res
);

    localparam int CW = $clog2(MAX_BAD + 1);
    localparam int AW = (MAX_BAD > 1) ? $clog2(MAX_BAD) : 1;
    localparam int AL = sbr_pkg::ALU_W;

    sbr_pkg::t_state r_state, n_state;
    sbr_pkg::t_in    r_item, n_item;
    sbr_pkg::t_out   r_out, n_out;

    logic [CW-1:0]  r_n, n_n;
    logic [CW-1:0]  r_idx, n_idx;
    logic           r_pend, n_pend;
    logic [AW-1:0]  r_pidx, n_pidx;
    logic [4:0]     r_step, n_step;
    logic [4:0]     r_rem, n_rem;
    logic [16:0]    r_quo, n_quo;
    logic [16:0]    r_lo, n_lo;
    logic [16:0]    r_hix, n_hix;
    logic [AL-1:0]  r_p, n_p;
    logic [15:0]    r_carry, n_carry;
    logic           r_dup, n_dup;
    logic           r_done, n_done;
    logic [CW-1:0]  r_bad, n_bad;

    sbr_pkg::t_alu_req alu_req;
    logic [AL-1:0]     alu_sum;
    logic              alu_carry;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [15:0]       ram_wdata;
    logic [15:0]       ram_rdata;

    logic              copy_bad;
    logic              full;
    logic              in_region;
    logic [AL-1:0]     d_ext;
    logic              in_walk;
    logic              clear_start;

    sbr_alu u_alu (
        .i_req   (alu_req),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    sbr_ram #(
        .W     (16),
        .DEPTH (MAX_BAD),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign copy_bad = (i_cfg.copies == 5'd0)
                   || ({1'b0, i_item.copy} >= i_cfg.copies)
                   || (32'(i_item.copy) >= sbr_pkg::MAX_COPIES);
    assign full      = (r_n == CW'(MAX_BAD));
    assign d_ext     = {2'b00, ram_rdata};
    assign in_region = (d_ext >= {1'b0, r_lo}) && (d_ext < {1'b0, r_hix});
    assign in_walk   = (r_state == sbr_pkg::S_SCAN) || (r_state == sbr_pkg::S_FIN);
    assign clear_start = i_start && (i_item.command == sbr_pkg::CMD_CLEAR);

    always_comb begin
        alu_req = '0;
        unique case (r_state)
            sbr_pkg::S_DIV: begin
                alu_req.a   = {12'd0, r_rem, r_quo[16]};
                alu_req.b   = {13'd0, i_cfg.copies};
                alu_req.sub = 1'b1;
            end
            sbr_pkg::S_MUL: begin
                alu_req.a = {1'b0, r_lo};
                alu_req.b = r_item.copy[r_step[1:0]] ? (({1'b0, r_quo}) << r_step[1:0])
                                                     : '0;
            end
            sbr_pkg::S_HI: begin
                alu_req.a = {1'b0, r_lo};
                alu_req.b = {1'b0, r_quo};
            end
            sbr_pkg::S_BASE: begin
                alu_req.a = {1'b0, r_lo};
                alu_req.b = {2'b00, r_item.block};
            end
            sbr_pkg::S_FIN: begin
                alu_req.a   = {1'b0, r_quo};
                alu_req.b   = AL'(r_bad);
                alu_req.sub = 1'b1;
            end
            default: begin
                alu_req = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sbr_pkg::S_IDLE: begin
                if (i_start) begin
                    unique case (i_item.command)
                        sbr_pkg::CMD_CLEAR: n_state = sbr_pkg::S_DONE;
                        sbr_pkg::CMD_ADD:   n_state = sbr_pkg::S_SCAN;
                        default:            n_state = copy_bad ? sbr_pkg::S_DONE
                                                               : sbr_pkg::S_DIV;
                    endcase
                end
            end
            sbr_pkg::S_DIV: begin
                if (r_step == 5'(sbr_pkg::DIV_STEPS - 1)) begin
                    n_state = sbr_pkg::S_MUL;
                end
            end
            sbr_pkg::S_MUL: begin
                if (r_step == 5'(sbr_pkg::MUL_STEPS - 1)) begin
                    n_state = sbr_pkg::S_HI;
                end
            end
            sbr_pkg::S_HI:   n_state = sbr_pkg::S_BASE;
            sbr_pkg::S_BASE: n_state = sbr_pkg::S_SCAN;
            sbr_pkg::S_SCAN: begin
                if (!r_pend && (r_idx >= r_n)) begin
                    n_state = sbr_pkg::S_FIN;
                end
            end
            sbr_pkg::S_FIN:  n_state = sbr_pkg::S_DONE;
            sbr_pkg::S_DONE: begin
                if (i_res_take) begin
                    n_state = sbr_pkg::S_IDLE;
                end
            end
            default: n_state = sbr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_item    = r_item;
        n_out     = r_out;
        n_n       = r_n;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_pidx    = r_pidx;
        n_step    = r_step;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_lo      = r_lo;
        n_hix     = r_hix;
        n_p       = r_p;
        n_carry   = r_carry;
        n_dup     = r_dup;
        n_done    = r_done;
        n_bad     = r_bad;
        ram_we    = 1'b0;
        ram_waddr = r_pidx;
        ram_wdata = r_carry;
        unique case (r_state)
            sbr_pkg::S_IDLE: begin
                if (i_start) begin
                    n_item  = i_item;
                    n_out   = '0;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_step  = '0;
                    n_rem   = '0;
                    n_quo   = i_cfg.total;
                    n_lo    = '0;
                    n_carry = i_item.mark_block;
                    n_dup   = 1'b0;
                    n_done  = 1'b0;
                    n_bad   = '0;
                    if (i_item.command == sbr_pkg::CMD_CLEAR) begin
                        n_n = '0;
                    end else if (i_item.command != sbr_pkg::CMD_ADD && copy_bad) begin
                        n_out.status = sbr_pkg::ST_COPY;
                    end
                end
            end
            sbr_pkg::S_DIV: begin
                n_rem  = alu_carry ? alu_sum[4:0] : {r_rem[3:0], r_quo[16]};
                n_quo  = {r_quo[15:0], alu_carry};
                n_step = (r_step == 5'(sbr_pkg::DIV_STEPS - 1)) ? '0 : r_step + 5'd1;
            end
            sbr_pkg::S_MUL: begin
                n_lo   = alu_sum[16:0];
                n_step = r_step + 5'd1;
            end
            sbr_pkg::S_HI: begin
                n_hix = alu_sum[16:0];
            end
            sbr_pkg::S_BASE: begin
                n_p = alu_sum;
            end
            sbr_pkg::S_SCAN: begin
                // issue the next read while the previous entry is compared
                if (r_idx < r_n) begin
                    n_idx  = r_idx + CW'(1);
                    n_pend = 1'b1;
                    n_pidx = r_idx[AW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    unique case (r_item.command)
                        sbr_pkg::CMD_ADD: begin
                            if (ram_rdata == r_carry) begin
                                n_dup = 1'b1;
                            end else if (!r_dup && (r_carry < ram_rdata)) begin
                                n_carry = ram_rdata;
                                ram_we  = !full;
                            end
                        end
                        sbr_pkg::CMD_MAP: begin
                            if (in_region && !r_done) begin
                                if (r_p < d_ext) begin
                                    n_done = 1'b1;
                                end else begin
                                    n_p = r_p + AL'(1);
                                end
                            end
                        end
                        sbr_pkg::CMD_COUNT: begin
                            if (in_region) begin
                                n_bad = r_bad + CW'(1);
                            end
                        end
                        default: begin
                            n_dup = r_dup;
                        end
                    endcase
                end
            end
            sbr_pkg::S_FIN: begin
                unique case (r_item.command)
                    sbr_pkg::CMD_ADD: begin
                        if (!r_dup) begin
                            if (full) begin
                                n_out.status = sbr_pkg::ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_n[AW-1:0];
                                n_n       = r_n + CW'(1);
                            end
                        end
                    end
                    sbr_pkg::CMD_MAP: begin
                        if (r_p < {1'b0, r_hix}) begin
                            n_out.phys_block = r_p[15:0];
                        end else begin
                            n_out.status = sbr_pkg::ST_RANGE;
                        end
                    end
                    sbr_pkg::CMD_COUNT: begin
                        n_out.usable_count = alu_carry ? alu_sum[16:0] : '0;
                    end
                    default: begin
                        n_out = r_out;
                    end
                endcase
            end
            default: begin
                n_out = r_out;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbr_pkg::S_IDLE;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_out   <= n_out;
        r_idx   <= n_idx;
        r_pend  <= n_pend;
        r_pidx  <= n_pidx;
        r_step  <= n_step;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_lo    <= n_lo;
        r_hix   <= n_hix;
        r_p     <= n_p;
        r_carry <= n_carry;
        r_dup   <= n_dup;
        r_done  <= n_done;
        r_bad   <= n_bad;
    end

    assign o_busy     = (r_state != sbr_pkg::S_IDLE);
    assign o_res.valid = (r_state == sbr_pkg::S_DONE);
    assign o_res.data  = r_out;

    `SBR_CHECK(a_fill_bound, r_n <= CW'(MAX_BAD), "table fill beyond capacity")
    `SBR_IMPLIES(a_start_idle, i_start, r_state == sbr_pkg::S_IDLE, "transfer while busy")
    `SBR_IMPLIES(a_write_phase, ram_we, in_walk, "table write outside walk")
    `SBR_NEXT(a_clear_empties, clear_start, r_n == '0, "clear left entries")

endmodule

`default_nettype wire

// File: rtl/core/skip_block_bad_block_remap.sv
// Top level of the skip-block bad-block remapper: configuration registers, output register.
// Depends on sbr_pkg, sbr_seq (with sbr_alu, sbr_ram) and assert_macros.svh.
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_stall    i_data  (sbr_pkg::t_in)
//   result    out        o_valid / i_stall    o_data  (sbr_pkg::t_out)
//   config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// Clear, and map or count on an invalid copy, go straight from idle to the result state.
// Add walks the table, one table entry per cycle, then appends in a finish step.
// Map and count run 17 divide steps, 4 multiply steps, 2 setup additions on the shared
// adder, the table walk and a finish step.
// Reset clears control state and the entry count; table contents stay undefined, no clearing pass.
// A result waits under i_stall while the next item is taken; a second one holds the sequencer.
`default_nettype none
`include "assert_macros.svh"

module skip_block_bad_block_remap #(
    parameter int MAX_BAD = sbr_pkg::MAX_BAD_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire sbr_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_stall,
    output sbr_pkg::t_out      o_data,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_idx,
    input  wire logic [16:0]   i_cfg_data
);

    logic [4:0]     r_copies;
    logic [16:0]    r_block_count;
    logic           r_ovalid, n_ovalid;
    sbr_pkg::t_out  r_odata;

    sbr_pkg::t_cfg  cfg;
    sbr_pkg::t_res  res;
    logic           busy;
    logic           start;
    logic           take;

    assign cfg.copies = r_copies;
    assign cfg.total  = (r_block_count > sbr_pkg::DEV_LIMIT) ? sbr_pkg::DEV_LIMIT
                                                             : r_block_count;

    assign start = i_valid && !busy;
    assign take  = res.valid && (!r_ovalid || !i_stall);

    sbr_seq #(
        .MAX_BAD (MAX_BAD)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (i_data),
        .i_cfg      (cfg),
        .i_res_take (take),
        .o_busy     (busy),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_copies      <= 5'd1;
            r_block_count <= 17'd4096;
        end else if (i_cfg_we) begin
            unique case (sbr_pkg::t_cfg_idx'(i_cfg_idx))
                sbr_pkg::CFG_COPIES:      r_copies      <= i_cfg_data[4:0];
                sbr_pkg::CFG_BLOCK_COUNT: r_block_count <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        n_ovalid = r_ovalid;
        priority if (take) begin
            n_ovalid = 1'b1;
        end else if (!i_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_odata <= res.data;
        end
    end

    assign o_stall = busy;
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    `SBR_IMPLIES(a_no_overwrite, r_ovalid && i_stall, !take, "held result overwritten")
    `SBR_NEXT(a_take_shows, take, r_ovalid, "taken result not presented")

endmodule

`default_nettype wire
